@@ design/tree_lca_path_middle_defines.svh @@
// Assertion macros shared by the ancestor engine modules.
`ifndef TREE_LCA_PATH_MIDDLE_DEFINES_SVH
`define TREE_LCA_PATH_MIDDLE_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define TLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define TLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/tlp_pkg.sv @@
// Package with the types, sizes and micro-operation codes of the ancestor engine.
package tlp_pkg;

	// Field widths fixed by the transaction format.
	localparam int ID_W    = 10;
	localparam int DEPTH_W = 10;
	localparam int PATH_W  = DEPTH_W + 1;

	// Tree capacity. MAX_NODES must be a power of two.
	localparam int MAX_NODES = 1024;
	localparam int LEVELS    = 10;

	localparam int SLOT_W   = $clog2(MAX_NODES);
	localparam int AT_DEPTH = MAX_NODES * LEVELS;
	localparam int AT_AW    = $clog2(AT_DEPTH);
	localparam int LVL_W    = $clog2(LEVELS + 1);
	localparam int SW       = ((DEPTH_W > LEVELS) ? DEPTH_W : LEVELS) + 2;
	localparam int STEP_W   = 5;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

	// Operation codes.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic              op;
		logic [ID_W-1:0]   node_a;
		logic [ID_W-1:0]   node_b;
		logic              is_root;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0]   middle_node;
		logic [ID_W-1:0]   common_ancestor;
		logic [PATH_W-1:0] path_length;
	} res_t;

	// One jump table entry: a valid flag and an ancestor id.
	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
	} entry_t;

	// Datapath micro-operations.
	typedef enum logic [4:0] {
		A_NOP      = 5'd0,
		A_RD_DEP_B = 5'd1,
		A_L_BASE   = 5'd2,
		A_L_RD     = 5'd3,
		A_L_WR     = 5'd4,
		A_L_DEP    = 5'd5,
		A_Q_DV     = 5'd6,
		A_Q_DU     = 5'd7,
		A_Q_ORDER  = 5'd8,
		A_CL_TEST  = 5'd9,
		A_CL_JUMP  = 5'd10,
		A_CL_DEP   = 5'd11,
		A_J_INIT   = 5'd12,
		A_J_RD_X   = 5'd13,
		A_J_RD_Y   = 5'd14,
		A_J_UPD    = 5'd15,
		A_RD_X0    = 5'd16,
		A_SET_C_E  = 5'd17,
		A_SET_C_X  = 5'd18,
		A_Q_DIST   = 5'd19,
		A_Q_PICK   = 5'd20,
		A_EMIT     = 5'd21
	} act_t;

	// Jump conditions of the sequencer.
	typedef enum logic [2:0] {
		C_NEVER     = 3'd0,
		C_ALWAYS    = 3'd1,
		C_IDLE_WAIT = 3'd2,
		C_QUERY     = 3'd3,
		C_LVL_END   = 3'd4,
		C_LVL_NZ    = 3'd5,
		C_X_EQ_Y    = 3'd6
	} cond_t;

	// One control word of the microprogram.
	typedef struct packed {
		act_t              act;
		cond_t             cond;
		logic [STEP_W-1:0] tgt;
	} uword_t;

	// Sequencer to datapath.
	typedef struct packed {
		logic accept;
		act_t act;
	} ctl_t;

	// Datapath to sequencer.
	typedef struct packed {
		logic is_query;
		logic lvl_end;
		logic lvl_nz;
		logic x_eq_y;
	} stat_t;

endpackage

@@ design/tree_lca_path_middle.sv @@
// Top level of the binary-lifting ancestor engine.
//
// A transaction is taken at a rising edge where start is high and busy is low. A load
// (op zero) stores the node's depth and fills its jump table from its parent's; it keeps
// busy high until the fill is done and gives no result. A query keeps busy high until
// its result is ready, ending sooner when the lifted endpoint is the other endpoint, and
// then presents middle node, common ancestor and path length on result for exactly one
// cycle with done high; the receiver cannot hold a result off, and a new transaction may
// start in that same cycle. A transaction's length is set by the single read port of the jump
// table memory and the depth store: each level of the two climbs and of the joint step
// needs its own memory reads in separate microprogram steps. Parents must be loaded
// before their children; entries of nodes that were never loaded read back as anything,
// and there is no clearing pass after reset.
`include "tree_lca_path_middle_defines.svh"

module tree_lca_path_middle (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tlp_pkg::cmd_t cmd,
	output logic          done,
	output tlp_pkg::res_t result
);
	import tlp_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	tlp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	tlp_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

	// A result only appears once the engine has finished its work.
	`TLP_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy, "result strobe while busy")
	// An accepted transaction always occupies the engine.
	`TLP_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy, "accepted transaction did not raise busy")

endmodule

@@ design/tlp_ram.sv @@
// Generic single-write, single-read memory with a registered read port.
module tlp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/tlp_seq.sv @@
// Microprogram sequencer: step counter, control store and conditional jumps.
`include "tree_lca_path_middle_defines.svh"

module tlp_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  tlp_pkg::stat_t stat,
	output tlp_pkg::ctl_t  ctl,
	output logic           busy
);
	import tlp_pkg::*;

	// Step addresses of the microprogram.
	localparam logic [STEP_W-1:0] S_IDLE   = STEP_W'(0);
	localparam logic [STEP_W-1:0] S_DISP   = STEP_W'(1);
	localparam logic [STEP_W-1:0] S_L_BASE = STEP_W'(2);
	localparam logic [STEP_W-1:0] S_L_RD   = STEP_W'(3);
	localparam logic [STEP_W-1:0] S_L_WR   = STEP_W'(4);
	localparam logic [STEP_W-1:0] S_L_DEP  = STEP_W'(5);
	localparam logic [STEP_W-1:0] S_Q_DV   = STEP_W'(6);
	localparam logic [STEP_W-1:0] S_Q_DU   = STEP_W'(7);
	localparam logic [STEP_W-1:0] S_Q_ORD  = STEP_W'(8);
	localparam logic [STEP_W-1:0] S_C1_T   = STEP_W'(9);
	localparam logic [STEP_W-1:0] S_C1_J   = STEP_W'(10);
	localparam logic [STEP_W-1:0] S_C1_D   = STEP_W'(11);
	localparam logic [STEP_W-1:0] S_J_CHK  = STEP_W'(12);
	localparam logic [STEP_W-1:0] S_J_RX   = STEP_W'(13);
	localparam logic [STEP_W-1:0] S_J_RY   = STEP_W'(14);
	localparam logic [STEP_W-1:0] S_J_UPD  = STEP_W'(15);
	localparam logic [STEP_W-1:0] S_J_E0   = STEP_W'(16);
	localparam logic [STEP_W-1:0] S_C_E    = STEP_W'(17);
	localparam logic [STEP_W-1:0] S_C_X    = STEP_W'(18);
	localparam logic [STEP_W-1:0] S_DIST   = STEP_W'(19);
	localparam logic [STEP_W-1:0] S_PICK   = STEP_W'(20);
	localparam logic [STEP_W-1:0] S_C2_T   = STEP_W'(21);
	localparam logic [STEP_W-1:0] S_C2_J   = STEP_W'(22);
	localparam logic [STEP_W-1:0] S_C2_D   = STEP_W'(23);
	localparam logic [STEP_W-1:0] S_EMIT   = STEP_W'(24);

	// Control store. A word that does not jump falls through to the next step.
	function automatic uword_t ucode(input logic [STEP_W-1:0] s);
		uword_t w;
		case (s)
			S_IDLE:   w = '{A_NOP,      C_IDLE_WAIT, S_IDLE};
			S_DISP:   w = '{A_RD_DEP_B, C_QUERY,     S_Q_DV};
			// Load: first entry, then each level from the previous ancestor.
			S_L_BASE: w = '{A_L_BASE,   C_NEVER,     S_IDLE};
			S_L_RD:   w = '{A_L_RD,     C_LVL_END,   S_L_DEP};
			S_L_WR:   w = '{A_L_WR,     C_ALWAYS,    S_L_RD};
			S_L_DEP:  w = '{A_L_DEP,    C_ALWAYS,    S_IDLE};
			// Query: endpoint depths and ordering.
			S_Q_DV:   w = '{A_Q_DV,     C_NEVER,     S_IDLE};
			S_Q_DU:   w = '{A_Q_DU,     C_NEVER,     S_IDLE};
			S_Q_ORD:  w = '{A_Q_ORDER,  C_NEVER,     S_IDLE};
			// Lift the deeper endpoint to the other one's depth.
			S_C1_T:   w = '{A_CL_TEST,  C_NEVER,     S_IDLE};
			S_C1_J:   w = '{A_CL_JUMP,  C_NEVER,     S_IDLE};
			S_C1_D:   w = '{A_CL_DEP,   C_LVL_NZ,    S_C1_T};
			// Joint climb unless the endpoints already meet.
			S_J_CHK:  w = '{A_J_INIT,   C_X_EQ_Y,    S_C_X};
			S_J_RX:   w = '{A_J_RD_X,   C_NEVER,     S_IDLE};
			S_J_RY:   w = '{A_J_RD_Y,   C_NEVER,     S_IDLE};
			S_J_UPD:  w = '{A_J_UPD,    C_LVL_NZ,    S_J_RX};
			S_J_E0:   w = '{A_RD_X0,    C_NEVER,     S_IDLE};
			S_C_E:    w = '{A_SET_C_E,  C_ALWAYS,    S_DIST};
			S_C_X:    w = '{A_SET_C_X,  C_NEVER,     S_IDLE};
			// Path length and the side that holds the middle node.
			S_DIST:   w = '{A_Q_DIST,   C_NEVER,     S_IDLE};
			S_PICK:   w = '{A_Q_PICK,   C_NEVER,     S_IDLE};
			// Climb to the middle node.
			S_C2_T:   w = '{A_CL_TEST,  C_NEVER,     S_IDLE};
			S_C2_J:   w = '{A_CL_JUMP,  C_NEVER,     S_IDLE};
			S_C2_D:   w = '{A_CL_DEP,   C_LVL_NZ,    S_C2_T};
			S_EMIT:   w = '{A_EMIT,     C_ALWAYS,    S_IDLE};
			default:  w = '{A_NOP,      C_ALWAYS,    S_IDLE};
		endcase
		return w;
	endfunction

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	uword_t            uw;
	logic              taken;

	// Decode the current word and choose the next step.
	always_comb begin
		uw = ucode(step_q);
		case (uw.cond)
			C_NEVER:     taken = 1'b0;
			C_ALWAYS:    taken = 1'b1;
			C_IDLE_WAIT: taken = !start;
			C_QUERY:     taken = stat.is_query;
			C_LVL_END:   taken = stat.lvl_end;
			C_LVL_NZ:    taken = stat.lvl_nz;
			C_X_EQ_Y:    taken = stat.x_eq_y;
			default:     taken = 1'b0;
		endcase
		step_d = taken ? uw.tgt : step_q + STEP_W'(1);
	end

	assign busy       = (step_q != S_IDLE);
	assign ctl.accept = start && !busy;
	assign ctl.act    = uw.act;

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// The block only returns to idle from the end of a load or of a query.
	`TLP_ASSERT_IMP(a_idle_entry, clk, arst_n, $fell(busy), ($past(step_q) == S_L_DEP) || ($past(step_q) == S_EMIT), "sequencer returned to idle from an unexpected step")

endmodule

@@ design/tlp_dp.sv @@
// Datapath: depth store, jump table memory and the registers the microprogram drives.
`include "tree_lca_path_middle_defines.svh"

module tlp_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  tlp_pkg::ctl_t ctl,
	input  tlp_pkg::cmd_t cmd,
	output tlp_pkg::stat_t stat,
	output logic          done,
	output tlp_pkg::res_t result
);
	import tlp_pkg::*;

	localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

	// Storage slot of a node id.
	function automatic logic [SLOT_W-1:0] slot_of(input logic [ID_W-1:0] id);
		logic [ID_W+SLOT_W-1:0] wide;
		wide = (ID_W + SLOT_W)'(id);
		return wide[SLOT_W-1:0];
	endfunction

	// Jump table address of one node and level.
	function automatic logic [AT_AW-1:0] at_addr(input logic [ID_W-1:0] id,
		input logic [LVL_W-1:0] lv);
		return AT_AW'(slot_of(id)) * AT_AW'(LEVELS) + AT_AW'(lv);
	endfunction

	cmd_t               cmd_q;
	logic [ID_W-1:0]    x_q, y_q, c_q;
	logic [DEPTH_W-1:0] dx_q, du_q, dv_q, dc_q, ld_q;
	logic signed [SW-1:0] tgt_q;
	logic [LVL_W-1:0]   lvl_q;
	entry_t             e_q, p_q;
	logic               jmp_q;
	logic [PATH_W-1:0]  dist_q;
	res_t               res_q;
	logic               done_q;

	// Memory ports.
	logic               dep_we;
	logic [SLOT_W-1:0]  dep_waddr, dep_raddr;
	logic [DEPTH_W-1:0] dep_rdata;
	logic               an_we;
	logic [AT_AW-1:0]   an_waddr, an_raddr;
	entry_t             an_wdata, an_rdata;

	// Derived values.
	entry_t             base_ent, chain_ent;
	logic [ID_W-1:0]    x_jump, c_from_e;
	logic               joint_ok, climb_ok, pick_a;
	logic [DEPTH_W:0]   dep_inc;
	logic [DEPTH_W-1:0] ld_d;
	logic [DEPTH_W-1:0] half;
	logic [LVL_W-1:0]   lvl_dec;
	logic signed [SW-1:0] dx_s, pow_s, du_s, dv_s, dc_s, rd_s, half_s, sum_s, tgt_pick;
	logic [PATH_W-1:0]  dist_d;

	// Combinational helpers for the micro-operations.
	always_comb begin
		base_ent  = cmd_q.is_root ? '0 : '{valid: 1'b1, id: cmd_q.node_b};
		chain_ent = p_q.valid ? an_rdata : '0;
		x_jump    = (jmp_q && an_rdata.valid) ? an_rdata.id : x_q;
		c_from_e  = an_rdata.valid ? an_rdata.id : x_q;
		joint_ok  = (e_q != an_rdata) && e_q.valid && an_rdata.valid;
		lvl_dec   = lvl_q - LVL_W'(1);

		// Parent depth plus one, saturating.
		dep_inc = {1'b0, dep_rdata} + (DEPTH_W + 1)'(1);
		ld_d    = cmd_q.is_root ? '0 : (dep_inc[DEPTH_W] ? DEPTH_MAX : dep_inc[DEPTH_W-1:0]);

		// Climb test: a step of 2^level may not pass the target depth.
		dx_s     = SW'(dx_q);
		pow_s    = SW'(1) << lvl_q;
		climb_ok = (dx_s - pow_s) >= tgt_q;

		// Path length, clamped at zero.
		du_s  = SW'(du_q);
		dv_s  = SW'(dv_q);
		dc_s  = SW'(dc_q);
		rd_s  = SW'(dep_rdata);
		sum_s = du_s + dv_s - (rd_s <<< 1);
		dist_d = (sum_s < 0) ? '0 : sum_s[PATH_W-1:0];

		// The middle node lies on the first endpoint's side if it is far enough up.
		half     = dist_q[PATH_W-1:1];
		half_s   = SW'(half);
		pick_a   = (du_s - dc_s) >= half_s;
		tgt_pick = pick_a ? (du_s - half_s) : (dv_s - half_s);
	end

	// Memory addresses per micro-operation.
	always_comb begin
		case (ctl.act)
			A_RD_DEP_B: dep_raddr = slot_of(cmd_q.node_b);
			A_Q_DV:     dep_raddr = slot_of(cmd_q.node_a);
			A_CL_JUMP:  dep_raddr = slot_of(x_jump);
			A_SET_C_E:  dep_raddr = slot_of(c_from_e);
			default:    dep_raddr = slot_of(x_q);
		endcase
		case (ctl.act)
			A_L_RD:   an_raddr = at_addr(p_q.id, lvl_dec);
			A_J_RD_Y: an_raddr = at_addr(y_q, lvl_q);
			A_RD_X0:  an_raddr = at_addr(x_q, '0);
			default:  an_raddr = at_addr(x_q, lvl_q);
		endcase
		an_we     = (ctl.act == A_L_BASE) || (ctl.act == A_L_WR);
		an_waddr  = (ctl.act == A_L_BASE) ? at_addr(cmd_q.node_a, '0)
			: at_addr(cmd_q.node_a, lvl_q);
		an_wdata  = (ctl.act == A_L_BASE) ? base_ent : chain_ent;
		dep_we    = (ctl.act == A_L_DEP);
		dep_waddr = slot_of(cmd_q.node_a);
	end

	tlp_ram #(.WIDTH($bits(entry_t)), .DEPTH(AT_DEPTH)) u_anc_ram (
		.clk   (clk),
		.we    (an_we),
		.waddr (an_waddr),
		.wdata (an_wdata),
		.raddr (an_raddr),
		.rdata (an_rdata)
	);

	tlp_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_dep_ram (
		.clk   (clk),
		.we    (dep_we),
		.waddr (dep_waddr),
		.wdata (ld_q),
		.raddr (dep_raddr),
		.rdata (dep_rdata)
	);

	// Working registers updated by the micro-operations.
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q <= cmd;
		end
		case (ctl.act)
			A_L_BASE: begin
				p_q   <= base_ent;
				lvl_q <= LVL_W'(1);
				ld_q  <= ld_d;
			end
			A_L_WR: begin
				p_q   <= chain_ent;
				lvl_q <= lvl_q + LVL_W'(1);
			end
			A_Q_DV: dv_q <= dep_rdata;
			A_Q_DU: du_q <= dep_rdata;
			A_Q_ORDER: begin
				if (du_q >= dv_q) begin
					x_q   <= cmd_q.node_a;
					y_q   <= cmd_q.node_b;
					dx_q  <= du_q;
					tgt_q <= SW'(dv_q);
				end else begin
					x_q   <= cmd_q.node_b;
					y_q   <= cmd_q.node_a;
					dx_q  <= dv_q;
					tgt_q <= SW'(du_q);
				end
				lvl_q <= LVL_TOP;
			end
			A_CL_TEST: jmp_q <= climb_ok;
			A_CL_JUMP: x_q <= x_jump;
			A_CL_DEP: begin
				dx_q  <= dep_rdata;
				lvl_q <= lvl_dec;
			end
			A_J_INIT: lvl_q <= LVL_TOP;
			A_J_RD_Y: e_q <= an_rdata;
			A_J_UPD: begin
				if (joint_ok) begin
					x_q <= e_q.id;
					y_q <= an_rdata.id;
				end
				lvl_q <= lvl_dec;
			end
			A_SET_C_E: c_q <= c_from_e;
			A_SET_C_X: c_q <= x_q;
			A_Q_DIST: begin
				dc_q   <= dep_rdata;
				dist_q <= dist_d;
			end
			A_Q_PICK: begin
				x_q   <= pick_a ? cmd_q.node_a : cmd_q.node_b;
				dx_q  <= pick_a ? du_q : dv_q;
				tgt_q <= tgt_pick;
				lvl_q <= LVL_TOP;
			end
			A_EMIT: begin
				res_q.middle_node     <= x_q;
				res_q.common_ancestor <= c_q;
				res_q.path_length     <= dist_q;
			end
			default: ;
		endcase
	end

	// Result strobe lasts one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctl.act == A_EMIT);
		end
	end

	assign stat.is_query = (cmd_q.op == OP_QUERY);
	assign stat.lvl_end  = (lvl_q == LVL_W'(LEVELS));
	assign stat.lvl_nz   = (lvl_q != '0);
	assign stat.x_eq_y   = (x_q == y_q);
	assign done          = done_q;
	assign result        = res_q;

	// Table fill writes only the levels above the first one.
	`TLP_ASSERT_IMP(a_fill_level, clk, arst_n, ctl.act == A_L_WR, (lvl_q != '0) && (lvl_q < LVL_W'(LEVELS)), "jump table fill outside the level range")
	// Climbs and joint steps stay inside the table.
	`TLP_ASSERT_IMP(a_walk_level, clk, arst_n, (ctl.act == A_CL_TEST) || (ctl.act == A_J_RD_X), lvl_q < LVL_W'(LEVELS), "walk level outside the table")

endmodule

@@ tb/tb_tree_lca_path_middle.sv @@
// Self-checking testbench for the binary-lifting ancestor engine tree_lca_path_middle.
`timescale 1ns / 100ps

module tb_tree_lca_path_middle;
	import tlp_pkg::*;

	logic clk;
	logic arst_n;
	logic start = 1'b0;
	logic busy;
	cmd_t cmd = '0;
	logic done;
	res_t result;

	tree_lca_path_middle dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// Transactions waiting for the driver, and answers waiting for the block.
	cmd_t tree_cmds[$];
	res_t lca_answers_due[$];

	// Shadow copy of the jump tables and depths, kept in step with accepted transactions.
	entry_t             jump_tab   [MAX_NODES][LEVELS];
	logic [DEPTH_W-1:0] node_depth [MAX_NODES];

	// Bookkeeping for the stimulus generator: which nodes hold written entries.
	bit ever_loaded [MAX_NODES];
	int loaded_ids[$];

	int   item_total  = 0;
	int   taken_count = 0;
	int   mismatches  = 0;
	int   idle_left   = 0;
	logic cmd_taken   = 1'b0;
	logic busy_seen   = 1'b0;
	res_t want;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// One line per mismatch, and a running count.
	task automatic flag_mismatch(string what, int got, int exp_val);
		$display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, exp_val);
		mismatches++;
	endtask

	function automatic int depth_at(logic [ID_W-1:0] x);
		return int'(node_depth[x]);
	endfunction

	// Climb from x by powers of two without going above the target depth.
	function automatic logic [ID_W-1:0] climb_to(logic [ID_W-1:0] x, int target);
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (depth_at(x) - (1 << i) >= target && jump_tab[x][i].valid)
				x = jump_tab[x][i].id;
		end
		return x;
	endfunction

	// Lowest common ancestor: level the endpoints, then lift both while they differ.
	function automatic logic [ID_W-1:0] lowest_common(logic [ID_W-1:0] u, logic [ID_W-1:0] v);
		logic [ID_W-1:0] t;
		entry_t eu;
		entry_t ev;
		if (depth_at(u) < depth_at(v)) begin
			t = u;
			u = v;
			v = t;
		end
		u = climb_to(u, depth_at(v));
		if (u == v)
			return u;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			eu = jump_tab[u][i];
			ev = jump_tab[v][i];
			if (eu != ev && eu.valid && ev.valid) begin
				u = eu.id;
				v = ev.id;
			end
		end
		// Endpoints in separate trees leave the lifted node as the answer.
		return jump_tab[u][0].valid ? jump_tab[u][0].id : u;
	endfunction

	// Apply one accepted transaction to the shadow tree; a query queues its answer.
	function automatic void tree_apply(cmd_t c);
		int              d;
		int              du;
		int              dv;
		int              dc;
		int              span;
		int              half;
		entry_t          prev;
		logic [ID_W-1:0] anc;
		logic [ID_W-1:0] mid;
		res_t            ans;
		if (c.op == OP_LOAD) begin
			if (c.is_root) begin
				d = 0;
				jump_tab[c.node_a][0] = '0;
			end else begin
				// Depth saturates at the largest value the store can hold.
				d = depth_at(c.node_b) + 1;
				if (d > int'(DEPTH_MAX))
					d = int'(DEPTH_MAX);
				jump_tab[c.node_a][0] = '{valid: 1'b1, id: c.node_b};
			end
			for (int i = 1; i < LEVELS; i++) begin
				prev = jump_tab[c.node_a][i-1];
				jump_tab[c.node_a][i] = prev.valid ? jump_tab[prev.id][i-1] : '0;
			end
			node_depth[c.node_a] = DEPTH_W'(d);
		end else begin
			anc  = lowest_common(c.node_a, c.node_b);
			du   = depth_at(c.node_a);
			dv   = depth_at(c.node_b);
			dc   = depth_at(anc);
			span = du + dv - 2 * dc;
			// Inconsistent trees can give a negative length, which reads as zero.
			if (span < 0)
				span = 0;
			half = span / 2;
			if (du - dc >= half)
				mid = climb_to(c.node_a, du - half);
			else
				mid = climb_to(c.node_b, dv - half);
			ans.middle_node     = mid;
			ans.common_ancestor = anc;
			ans.path_length     = PATH_W'(span);
			lca_answers_due.insert(lca_answers_due.size(), ans);
		end
	endfunction

	// Queue one transaction and note which nodes now hold written entries.
	function automatic void add_item(logic op, int a, int b, logic root);
		cmd_t c;
		c.op      = op;
		c.node_a  = ID_W'(a);
		c.node_b  = ID_W'(b);
		c.is_root = root;
		tree_cmds.insert(tree_cmds.size(), c);
		if (op == OP_LOAD && !ever_loaded[a]) begin
			ever_loaded[a] = 1'b1;
			loaded_ids.insert(loaded_ids.size(), a);
		end
	endfunction

	function automatic int pick_loaded();
		return loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
	endfunction

	// Driver: presents the next transaction after a random number of idle cycles.
	always @(negedge clk) begin
		if (arst_n && (!start || cmd_taken)) begin
			if (cmd_taken)
				idle_left = ((taken_count / 60) % 4 == 3) ? 0 : $urandom_range(0, 8);
			if (idle_left == 0 && tree_cmds.size() > 0) begin
				cmd   <= tree_cmds.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
				if (idle_left > 0 && !busy_seen)
					idle_left--;
			end
		end
	end

	// Monitor: checks each result, then records any transaction taken at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (lca_answers_due.size() == 0) begin
					flag_mismatch("result with no query outstanding",
						int'(result.path_length), -1);
				end else begin
					want = lca_answers_due.pop_front();
					if (result.middle_node !== want.middle_node)
						flag_mismatch("middle_node", int'(result.middle_node),
							int'(want.middle_node));
					if (result.common_ancestor !== want.common_ancestor)
						flag_mismatch("common_ancestor", int'(result.common_ancestor),
							int'(want.common_ancestor));
					if (result.path_length !== want.path_length)
						flag_mismatch("path_length", int'(result.path_length),
							int'(want.path_length));
				end
			end
			busy_seen = busy;
			cmd_taken = start && !busy;
			if (cmd_taken) begin
				tree_apply(cmd);
				taken_count++;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		int order [MAX_NODES];
		int round_ids[$];
		bit in_round [MAX_NODES];
		int n;
		int id;
		int par;
		int j;
		int t;
		int back;

		for (int k = 0; k < MAX_NODES; k++)
			for (int l = 0; l < LEVELS; l++)
				jump_tab[k][l] = '0;
		for (int k = 0; k < MAX_NODES; k++)
			node_depth[k] = '0;

		// Directed part: a small forest with a branch, a second tree and a re-rooted node.
		add_item(OP_LOAD, 0, 1023, 1'b1);
		add_item(OP_LOAD, 1, 0, 1'b0);
		add_item(OP_LOAD, 2, 1, 1'b0);
		add_item(OP_LOAD, 3, 0, 1'b0);
		add_item(OP_LOAD, 1023, 3, 1'b0);
		add_item(OP_LOAD, 'h2AA, 2, 1'b0);
		add_item(OP_LOAD, 'h155, 1023, 1'b0);
		add_item(OP_LOAD, 512, 'h155, 1'b1);
		add_item(OP_QUERY, 0, 0, 1'b0);
		add_item(OP_QUERY, 2, 2, 1'b1);
		add_item(OP_QUERY, 1, 2, 1'b0);
		add_item(OP_QUERY, 2, 1, 1'b1);
		add_item(OP_QUERY, 2, 1023, 1'b0);
		add_item(OP_QUERY, 1023, 2, 1'b0);
		add_item(OP_QUERY, 'h2AA, 'h155, 1'b0);
		add_item(OP_QUERY, 'h155, 'h2AA, 1'b1);
		add_item(OP_QUERY, 512, 2, 1'b0);
		add_item(OP_QUERY, 2, 512, 1'b0);
		add_item(OP_QUERY, 0, 1023, 1'b1);
		add_item(OP_LOAD, 3, 512, 1'b1);
		add_item(OP_QUERY, 1023, 1, 1'b0);
		add_item(OP_QUERY, 'h155, 'h2AA, 1'b0);
		add_item(OP_LOAD, 1, 1, 1'b0);
		add_item(OP_QUERY, 2, 0, 1'b0);

		// Random forests: parents are always loaded earlier in the same round.
		repeat (2) begin
			round_ids.delete();
			for (int k = 0; k < MAX_NODES; k++)
				in_round[k] = 1'b0;
			n = $urandom_range(50, 80);
			for (int k = 0; k < n; k++) begin
				do
					id = $urandom_range(0, MAX_NODES - 1);
				while (in_round[id]);
				if (round_ids.size() == 0 || $urandom_range(0, 15) == 0) begin
					add_item(OP_LOAD, id, $urandom_range(0, MAX_NODES - 1), 1'b1);
				end else begin
					// Favour recent nodes so that the trees grow deep as well as wide.
					if ($urandom_range(0, 1)) begin
						back = (round_ids.size() > 4) ? 4 : round_ids.size();
						par = round_ids[round_ids.size() - 1 - $urandom_range(0, back - 1)];
					end else begin
						par = round_ids[$urandom_range(0, round_ids.size() - 1)];
					end
					add_item(OP_LOAD, id, par, 1'b0);
				end
				in_round[id] = 1'b1;
				round_ids.insert(round_ids.size(), id);
				if ($urandom_range(0, 2) == 0) begin
					if ($urandom_range(0, 6) == 0)
						add_item(OP_QUERY, pick_loaded(), pick_loaded(),
							1'($urandom_range(0, 1)));
					else
						add_item(OP_QUERY, round_ids[$urandom_range(0, round_ids.size() - 1)],
							round_ids[$urandom_range(0, round_ids.size() - 1)],
							1'($urandom_range(0, 1)));
				end
			end
		end

		// One chain through every node id, deep enough to reach depth saturation.
		for (int k = 0; k < MAX_NODES; k++)
			order[k] = k;
		for (int k = MAX_NODES - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = order[k];
			order[k] = order[j];
			order[j] = t;
		end
		add_item(OP_LOAD, order[0], $urandom_range(0, MAX_NODES - 1), 1'b1);
		for (int k = 1; k < MAX_NODES; k++) begin
			add_item(OP_LOAD, order[k], order[k-1], 1'b0);
			if ($urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 9) == 0)
					add_item(OP_QUERY, order[$urandom_range(0, k)], pick_loaded(),
						1'($urandom_range(0, 1)));
				else
					add_item(OP_QUERY, order[$urandom_range(0, k)], order[$urandom_range(0, k)],
						1'($urandom_range(0, 1)));
			end
		end
		add_item(OP_QUERY, order[MAX_NODES - 1], order[0], 1'b0);
		add_item(OP_QUERY, order[0], order[MAX_NODES - 1], 1'b1);
		// Children of the deepest node stay at the saturated depth.
		add_item(OP_LOAD, order[5], order[MAX_NODES - 1], 1'b0);
		add_item(OP_QUERY, order[5], order[MAX_NODES - 1], 1'b0);
		add_item(OP_QUERY, order[5], order[0], 1'b0);
		add_item(OP_LOAD, order[MAX_NODES - 1], order[MAX_NODES - 1], 1'b0);
		add_item(OP_QUERY, order[MAX_NODES - 1], order[700], 1'b0);

		// Every node now holds written entries, so any mix of fields is fair.
		repeat (60) begin
			add_item(1'($urandom_range(0, 1)), $urandom_range(0, MAX_NODES - 1),
				$urandom_range(0, MAX_NODES - 1), 1'($urandom_range(0, 1)));
		end
		item_total = tree_cmds.size();

		// Reset once, then release it away from the active edge.
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (taken_count < item_total)
			@(posedge clk);
		while (lca_answers_due.size() != 0)
			@(posedge clk);
		// Allow a stray late result to show up before closing.
		repeat (2 * (9 * LEVELS + 10)) @(posedge clk);

		if (lca_answers_due.size() != 0)
			flag_mismatch("answers never delivered", 0, lca_answers_due.size());
		if (mismatches == 0)
			$display("PASS tree_lca_path_middle");
		else
			$display("FAIL tree_lca_path_middle");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#12_000_000;
		$display("FAIL tree_lca_path_middle");
		$finish;
	end

endmodule
